// ----- hdl/dhcp_opt_pkg.sv -----
`timescale 1ns / 1ps

package dhcp_opt_pkg;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_CODE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_CAPTURE = 3'd2,
    PH_SKIP    = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  // Option codes of interest.
  localparam logic [7:0] OPT_PAD     = 8'd0;
  localparam logic [7:0] OPT_NETMASK = 8'd1;
  localparam logic [7:0] OPT_ROUTER  = 8'd3;
  localparam logic [7:0] OPT_DNS     = 8'd6;
  localparam logic [7:0] OPT_LEASE   = 8'd51;
  localparam logic [7:0] OPT_OVLD    = 8'd52;
  localparam logic [7:0] OPT_MSGTYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER  = 8'd54;
  localparam logic [7:0] OPT_COOKIE  = 8'd99;
  localparam logic [7:0] OPT_END     = 8'hff;

  // Bytes of the magic cookie that follow its first byte.
  localparam logic [7:0] COOKIE_REST = 8'd3;

  // Slots of the address store.
  localparam int ADDR_SLOTS = 6;
  localparam logic [2:0] SLOT_MASK   = 3'd0;
  localparam logic [2:0] SLOT_ROUTER = 3'd1;
  localparam logic [2:0] SLOT_DNS1   = 3'd2;
  localparam logic [2:0] SLOT_DNS2   = 3'd3;
  localparam logic [2:0] SLOT_LEASE  = 3'd4;
  localparam logic [2:0] SLOT_SERVER = 3'd5;

  // End status codes.
  localparam logic [1:0] ST_END_OPTION = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED  = 2'd2;

  // Result word width: 16 + 6 * 32 + 2 bits, filled up to whole bytes.
  localparam int RESULT_BITS = 210;
  localparam int RESULT_BYTES = (RESULT_BITS + 7) / 8;
  localparam int RESULT_WIDTH = RESULT_BYTES * 8;

  // True when a known option carries the length it is captured at.
  function automatic logic length_fits(input logic [7:0] code, input logic [7:0] len);
    logic fits;
    fits = 1'b0;
    if (code == OPT_NETMASK || code == OPT_ROUTER || code == OPT_LEASE ||
        code == OPT_SERVER) begin
      fits = (len == 8'd4);
    end else if (code == OPT_DNS) begin
      fits = (len == 8'd4) || (len == 8'd8);
    end else if (code == OPT_OVLD || code == OPT_MSGTYPE) begin
      fits = (len == 8'd1);
    end
    return fits;
  endfunction

endpackage

// ----- hdl/dhcp_option_parser.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Contents
// --------  ---------  ---------------------------------------------------------
// s_axis    in         tdata: option_byte; tuser: new_message; tlast: last_in_region
// m_axis    out        tdata: captured fields and end status, one word per region
//
// One input word is taken every cycle unless the input stalls; the parse state
// and capture store are updated in the cycle the word is accepted.
// A result word appears in the output register in the cycle after the last
// byte of a region is accepted.
// The input stalls only while a result waits in the output register and the
// downstream side holds m_axis_tready low.
// Reset clears the parse state, the capture store and the output valid flag.

module dhcp_option_parser
  import dhcp_opt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] option_byte
  input  logic                    s_axis_tuser,   // [0] new_message
  input  logic                    s_axis_tlast,   // last_in_region
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [7:0] message_type, [15:8] overload_flags, [47:16] subnet_mask,
  // [79:48] router_address, [111:80] dns_primary, [143:112] dns_secondary,
  // [175:144] lease_seconds, [207:176] server_address, [209:208] end_status,
  // [215:210] zero
  output logic [RESULT_WIDTH-1:0] m_axis_tdata
);

  // Parse state.
  phase_t      phase, phase_next;
  logic [7:0]  cur_code, cur_code_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [31:0] asm_word, asm_word_next;
  logic [2:0]  pay_idx, pay_idx_next;
  logic        end_seen, end_seen_next;

  // Capture store.
  logic [7:0]  cap_type, cap_type_next;
  logic [7:0]  cap_ovld, cap_ovld_next;
  logic [31:0] cap_addr [ADDR_SLOTS];
  logic [31:0] cap_addr_next [ADDR_SLOTS];

  logic        accept;
  logic [1:0]  status;
  logic [7:0]  b;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign b = s_axis_tdata;

  // Next state for one byte: optional clear, then the phase update.
  always_comb begin
    if (s_axis_tuser) begin
      phase_next      = PH_CODE;
      cur_code_next   = '0;
      bytes_left_next = '0;
      asm_word_next   = '0;
      pay_idx_next    = '0;
      end_seen_next   = 1'b0;
      cap_type_next   = '0;
      cap_ovld_next   = '0;
      for (int i = 0; i < ADDR_SLOTS; i++) begin
        cap_addr_next[i] = '0;
      end
    end else begin
      phase_next      = phase;
      cur_code_next   = cur_code;
      bytes_left_next = bytes_left;
      asm_word_next   = asm_word;
      pay_idx_next    = pay_idx;
      end_seen_next   = end_seen;
      cap_type_next   = cap_type;
      cap_ovld_next   = cap_ovld;
      for (int i = 0; i < ADDR_SLOTS; i++) begin
        cap_addr_next[i] = cap_addr[i];
      end
    end

    unique case (phase_next)
      PH_LEN: begin
        if (length_fits(cur_code_next, b)) begin
          phase_next      = PH_CAPTURE;
          bytes_left_next = b;
          pay_idx_next    = '0;
          asm_word_next   = '0;
        end else if (b == 8'd0) begin
          phase_next = PH_CODE;
        end else begin
          phase_next      = PH_SKIP;
          bytes_left_next = b;
        end
      end
      PH_CAPTURE, PH_SKIP: begin
        if (phase_next == PH_CAPTURE) begin
          asm_word_next = {asm_word_next[23:0], b};
          pay_idx_next  = pay_idx_next + 3'd1;
          if (cur_code_next == OPT_OVLD) begin
            cap_ovld_next = b;
          end else if (cur_code_next == OPT_MSGTYPE) begin
            cap_type_next = b;
          end else if (pay_idx_next[1:0] == 2'd0) begin
            // A full four-byte value is ready: store it in its slot.
            if (cur_code_next == OPT_NETMASK) begin
              cap_addr_next[SLOT_MASK] = asm_word_next;
            end else if (cur_code_next == OPT_ROUTER) begin
              cap_addr_next[SLOT_ROUTER] = asm_word_next;
            end else if (cur_code_next == OPT_DNS) begin
              if (pay_idx_next == 3'd4) begin
                cap_addr_next[SLOT_DNS1] = asm_word_next;
              end else begin
                cap_addr_next[SLOT_DNS2] = asm_word_next;
              end
            end else if (cur_code_next == OPT_LEASE) begin
              cap_addr_next[SLOT_LEASE] = asm_word_next;
            end else if (cur_code_next == OPT_SERVER) begin
              cap_addr_next[SLOT_SERVER] = asm_word_next;
            end
          end
        end
        bytes_left_next = bytes_left_next - 8'd1;
        if (bytes_left_next == 8'd0) begin
          phase_next = PH_CODE;
        end
      end
      PH_DONE: begin
      end
      default: begin
        if (b == OPT_PAD) begin
          phase_next = PH_CODE;
        end else if (b == OPT_END) begin
          phase_next    = PH_DONE;
          end_seen_next = 1'b1;
        end else if (b == OPT_COOKIE) begin
          cur_code_next   = b;
          phase_next      = PH_SKIP;
          bytes_left_next = COOKIE_REST;
        end else begin
          cur_code_next = b;
          phase_next    = PH_LEN;
        end
      end
    endcase

    // End status for a region closing on this byte.
    if (end_seen_next) begin
      status = ST_END_OPTION;
    end else if (phase_next == PH_CODE) begin
      status = ST_EXHAUSTED;
    end else begin
      status = ST_TRUNCATED;
    end
  end

  // Parse state and capture store; a region end returns the parser to idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CODE;
      cur_code   <= '0;
      bytes_left <= '0;
      asm_word   <= '0;
      pay_idx    <= '0;
      end_seen   <= 1'b0;
      cap_type   <= '0;
      cap_ovld   <= '0;
      for (int i = 0; i < ADDR_SLOTS; i++) begin
        cap_addr[i] <= '0;
      end
    end else if (accept) begin
      cap_type <= cap_type_next;
      cap_ovld <= cap_ovld_next;
      for (int i = 0; i < ADDR_SLOTS; i++) begin
        cap_addr[i] <= cap_addr_next[i];
      end
      if (s_axis_tlast) begin
        phase      <= PH_CODE;
        cur_code   <= '0;
        bytes_left <= '0;
        asm_word   <= '0;
        pay_idx    <= '0;
        end_seen   <= 1'b0;
      end else begin
        phase      <= phase_next;
        cur_code   <= cur_code_next;
        bytes_left <= bytes_left_next;
        asm_word   <= asm_word_next;
        pay_idx    <= pay_idx_next;
        end_seen   <= end_seen_next;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Output word, loaded when a region's last byte is accepted.
  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast) begin
      m_axis_tdata <= {{(RESULT_WIDTH - RESULT_BITS){1'b0}}, status,
                       cap_addr_next[SLOT_SERVER], cap_addr_next[SLOT_LEASE],
                       cap_addr_next[SLOT_DNS2], cap_addr_next[SLOT_DNS1],
                       cap_addr_next[SLOT_ROUTER], cap_addr_next[SLOT_MASK],
                       cap_ovld_next, cap_type_next};
    end
  end

  // A skip or capture phase always has bytes still to take.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP || phase == PH_CAPTURE) |-> bytes_left != 8'd0)
    else $error("payload phase with no bytes left");

  // The done phase is only reached through the end option.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> end_seen)
    else $error("done phase without end option");

  // A region end leaves the parser expecting a code, and a result pending.
  assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> (phase == PH_CODE && !end_seen && m_axis_tvalid))
    else $error("region end did not reset parser or raise result");

  // A result never carries the unused status code.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[RESULT_BITS-1 -: 2] != 2'd3)
    else $error("invalid end status");

endmodule
